@@ sv/csfj_pkg.sv @@
`default_nettype none
package csfj_pkg;

  localparam int PARTICLES_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IDX_W         = 10;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int UNIT_BITS     = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS = 1'b0,
    REG_DAMPING   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SPRING = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         index_a;
    logic [IDX_W-1:0]         index_b;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0]        rest_length;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic signed [DATA_W-1:0] jac_xx;
    logic signed [DATA_W-1:0] jac_xy;
    logic signed [DATA_W-1:0] jac_xz;
    logic signed [DATA_W-1:0] jac_yy;
    logic signed [DATA_W-1:0] jac_yz;
    logic signed [DATA_W-1:0] jac_zz;
    logic                     stretched;
    logic                     saturated;
  } res_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] pos;
    logic [2:0][DATA_W-1:0] vel;
  } particle_t;

endpackage
`default_nettype wire

@@ sv/csfj_in_if.sv @@
`default_nettype none
interface csfj_in_if;
  logic            valid;
  logic            ready;
  csfj_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/csfj_out_if.sv @@
`default_nettype none
interface csfj_out_if;
  logic            valid;
  logic            ready;
  csfj_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/cloth_spring_force_jacobian.sv @@
`default_nettype none
// Mass-spring force and position Jacobian unit for an implicit cloth solver. Particle
// positions and velocities live in one on-chip memory (one write port, two read ports,
// registered reads). A load request writes one particle and produces no result; a spring
// request reads both end particles and presents the damped
// force on the first particle, the six distinct entries of the symmetric position
// Jacobian, and the stretched / saturated flags. One request is taken every cycle while
// the result side is not stalled; the fully pipelined datapath has these stages:
// memory read (1), difference and squares (3), a 32-stage square root for the length,
// one compare stage, a 31-stage four-lane divider for the unit direction and length
// ratio, five multiply stages and the output register. A load is visible to every spring
// request taken after it. Entries never loaded read back as undefined data; there is no
// clearing pass after reset. Stiffness and damping must only be written while the block
// is idle.
module cloth_spring_force_jacobian #(
  parameter int PARTICLES = csfj_pkg::PARTICLES_DEF,
  parameter int FRAC_BITS = csfj_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  csfj_in_if.sink                         in_ch,
  csfj_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [csfj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csfj_pkg::DATA_W-1:0]     cfg_data
);

  localparam int IDX_W  = csfj_pkg::IDX_W;
  localparam int DW     = csfj_pkg::DATA_W;
  localparam int UB     = csfj_pkg::UNIT_BITS;
  localparam int AW     = $clog2(PARTICLES);
  localparam int EXT_W  = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int MW     = DW + 1;            // |dx|, |dv|, length
  localparam int SQW    = 2 * MW;            // one square
  localparam int SUMW   = SQW + 1;           // sum of three squares
  localparam int RT     = 32;                // root bits
  localparam int SRW    = 66;                // root remainder
  localparam int TPW    = DW + MW;           // 32 x 33 products
  localparam int FDW    = TPW - FRAC_BITS;   // damping term
  localparam int TW     = TPW - FRAC_BITS;   // tension
  localparam int TL     = (TW + 1) / 2;
  localparam int TH     = TW - TL;
  localparam int QW     = 31;                // quotient bits, Q1.30
  localparam int LANES  = 4;
  localparam int FCW    = TW + QW + 1;
  localparam int PMW    = 2 * QW;
  localparam int PW     = PMW - UB;
  localparam int SPW    = PW + 3;
  localparam int DMW    = SPW - 1;
  localparam int CDW    = QW + DMW;
  localparam int CSW    = CDW - UB;
  localparam int MSW    = CSW + 2;
  localparam int MMW    = MSW - 1;
  localparam int SMW    = DW + MMW;
  localparam int PAIRS  = 6;
  localparam int PI [PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [PAIRS] = '{0, 1, 2, 1, 2, 2};
  localparam logic [SPW-1:0] UNIT_ONE = SPW'(64'd1 << UB);

  typedef struct packed {
    logic [2:0][MW-1:0]  mx;
    logic [2:0]          sx;
    logic [2:0][FDW-1:0] fd;
    logic [2:0]          fds;
    logic [DW-1:0]       rest;
    logic                big;
  } sqc_t;

  typedef struct packed {
    logic [MW-1:0]       len;
    logic                act;
    logic                st;
    logic [2:0]          sx;
    logic [2:0][FDW-1:0] fd;
    logic [2:0]          fds;
    logic [TPW-1:0]      tp;
  } dvc_t;

  typedef struct packed {
    logic [2:0][63:0] f;
    logic             act;
    logic             st;
  } tail_t;

  function automatic logic [MW-1:0] mag_w(input logic [MW-1:0] v);
    return v[MW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [DW:0] sat_w(input logic [63:0] v);
    if ($signed(v) > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if ($signed(v) < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[DW-1:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake: whole pipeline advances unless the output register is held.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  csfj_pkg::res_t out_data_r;
  logic adv, acc, is_spring;

  assign adv            = !out_valid_r || out_ch.ready;
  assign in_ch.ready    = adv;
  assign acc            = in_ch.valid && adv;
  assign is_spring      = in_ch.data.req_type == csfj_pkg::REQ_SPRING;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.data    = out_data_r;

  // Configuration registers
  logic [DW-1:0] stiff_r, damp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= '0;
      damp_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csfj_pkg::REG_STIFFNESS: stiff_r <= cfg_data;
        csfj_pkg::REG_DAMPING:   damp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Particle memory. Write and both reads happen at the accept edge, so a load
  // is seen by every later spring request without forwarding.
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0] ia_ext, ib_ext;
  logic ia_ok, ib_ok, load_we;
  csfj_pkg::particle_t wr_word;
  csfj_pkg::particle_t mem [PARTICLES];
  csfj_pkg::particle_t rda_r, rdb_r;

  assign ia_ext  = EXT_W'(in_ch.data.index_a);
  assign ib_ext  = EXT_W'(in_ch.data.index_b);
  assign ia_ok   = ia_ext < EXT_W'(PARTICLES);
  assign ib_ok   = ib_ext < EXT_W'(PARTICLES);
  assign load_we = acc && !is_spring && ia_ok;
  assign wr_word.pos = {in_ch.data.pos_z, in_ch.data.pos_y, in_ch.data.pos_x};
  assign wr_word.vel = {in_ch.data.vel_z, in_ch.data.vel_y, in_ch.data.vel_x};

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[ia_ext[AW-1:0]] <= wr_word;
    end
    if (adv) begin
      rda_r <= mem[ia_ext[AW-1:0]];
      rdb_r <= mem[ib_ext[AW-1:0]];
    end
  end

  // Stage 0 side info
  logic v0_r, oka0_r, okb0_r;
  logic [DW-1:0] rest0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      oka0_r  <= ia_ok;
      okb0_r  <= ib_ok;
      rest0_r <= in_ch.data.rest_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: differences, out-of-range ends read as zero.
  // ---------------------------------------------------------------------------
  logic [2:0][DW-1:0] pa_c, pb_c, va_c, vb_c;
  logic [2:0][MW-1:0] dx_c, dv_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = oka0_r ? rda_r.pos[i] : '0;
      pb_c[i] = okb0_r ? rdb_r.pos[i] : '0;
      va_c[i] = oka0_r ? rda_r.vel[i] : '0;
      vb_c[i] = okb0_r ? rdb_r.vel[i] : '0;
      dx_c[i] = {pa_c[i][DW-1], pa_c[i]} - {pb_c[i][DW-1], pb_c[i]};
      dv_c[i] = {va_c[i][DW-1], va_c[i]} - {vb_c[i][DW-1], vb_c[i]};
    end
  end

  logic v1_r;
  logic [2:0][MW-1:0] mx1_r, dvm1_r;
  logic [2:0] sx1_r, dvs1_r;
  logic [DW-1:0] rest1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mx1_r[i]  <= mag_w(dx_c[i]);
        sx1_r[i]  <= dx_c[i][MW-1];
        dvm1_r[i] <= mag_w(dv_c[i]);
        dvs1_r[i] <= dv_c[i][MW-1];
      end
      rest1_r <= rest0_r;
    end
  end

  // Stage 2: squares and damping products
  logic v2_r;
  logic [2:0][SQW-1:0] sq2_r;
  logic [2:0][TPW-1:0] fdp2_r;
  logic [2:0][MW-1:0] mx2_r;
  logic [2:0] sx2_r, dvs2_r;
  logic [DW-1:0] rest2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]  <= SQW'(mx1_r[i]) * SQW'(mx1_r[i]);
        fdp2_r[i] <= TPW'(damp_r) * TPW'(dvm1_r[i]);
      end
      mx2_r   <= mx1_r;
      sx2_r   <= sx1_r;
      dvs2_r  <= dvs1_r;
      rest2_r <= rest1_r;
    end
  end

  // Stage 3: sum of squares
  logic v3_r;
  logic [SUMW-1:0] sum3_r;
  sqc_t s3c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum3_r <= SUMW'(sq2_r[0]) + SUMW'(sq2_r[1]) + SUMW'(sq2_r[2]);
      for (int i = 0; i < 3; i++) begin
        s3c_r.fd[i] <= FDW'(fdp2_r[i] >> FRAC_BITS);
      end
      s3c_r.mx   <= mx2_r;
      s3c_r.sx   <= sx2_r;
      s3c_r.fds  <= dvs2_r;
      s3c_r.rest <= rest2_r;
      s3c_r.big  <= 1'b0;
    end
  end

  // Sums at or above 2^64 take the root of sum/4 and double it.
  logic big3;
  logic [63:0] sqrt_x;
  sqc_t sqc_in;
  assign big3   = |sum3_r[SUMW-1:64];
  assign sqrt_x = big3 ? sum3_r[65:2] : sum3_r[63:0];
  always_comb begin
    sqc_in     = s3c_r;
    sqc_in.big = big3;
  end

  // ---------------------------------------------------------------------------
  // Square root, one root bit per stage; remainder kept as x - q^2.
  // ---------------------------------------------------------------------------
  logic [RT-1:0]  sq_q_r   [RT];
  logic [SRW-1:0] sq_rem_r [RT];
  sqc_t           sq_c_r   [RT];
  logic           sq_v_r   [RT];

  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    localparam int B = RT - 1 - k;
    logic [RT-1:0]  q_in;
    logic [SRW-1:0] rem_in, trial;
    sqc_t           c_in;
    logic           v_in;
    if (k == 0) begin : g_first
      assign q_in   = '0;
      assign rem_in = SRW'(sqrt_x);
      assign c_in   = sqc_in;
      assign v_in   = v3_r;
    end else begin : g_next
      assign q_in   = sq_q_r[k-1];
      assign rem_in = sq_rem_r[k-1];
      assign c_in   = sq_c_r[k-1];
      assign v_in   = sq_v_r[k-1];
    end
    assign trial = (SRW'(q_in) << (B + 1)) + (SRW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          sq_rem_r[k] <= rem_in - trial;
          sq_q_r[k]   <= q_in | (RT'(1) << B);
        end else begin
          sq_rem_r[k] <= rem_in;
          sq_q_r[k]   <= q_in;
        end
        sq_c_r[k] <= c_in;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k] <= v_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Length compare stage
  // ---------------------------------------------------------------------------
  logic [MW-1:0] len_c, e_c;
  logic st_c, act_c;
  assign len_c = sq_c_r[RT-1].big ? {sq_q_r[RT-1], 1'b0} : {1'b0, sq_q_r[RT-1]};
  assign st_c  = len_c >= MW'(sq_c_r[RT-1].rest);
  assign act_c = st_c && (len_c != '0);
  assign e_c   = act_c ? (len_c - MW'(sq_c_r[RT-1].rest)) : '0;

  logic vE_r, stE_r, actE_r;
  logic [MW-1:0] lenE_r, eE_r;
  sqc_t cE_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      lenE_r <= len_c;
      eE_r   <= e_c;
      stE_r  <= st_c;
      actE_r <= act_c;
      cE_r   <= sq_c_r[RT-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Four-lane restoring divider: n = |dx| * 2^30 / L, c = e * 2^30 / L.
  // Quotient is below 2^31, so the top of the dividend starts as the remainder.
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][MW-1:0] dv_rem_r [QW];
  logic [LANES-1:0][QW-1:0] dv_q_r   [QW];
  dvc_t                     dv_c_r   [QW];
  logic                     dv_v_r   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [LANES-1:0][MW-1:0] rem_in;
    logic [LANES-1:0][QW-1:0] q_in;
    logic [LANES-1:0]         bit_in, ge;
    logic [LANES-1:0][MW:0]   r2;
    dvc_t                     c_in;
    logic                     v_in;
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = cE_r.mx[i] >> 1;
          bit_in[i] = cE_r.mx[i][0];
        end
        rem_in[3]  = eE_r >> 1;
        bit_in[3]  = eE_r[0];
        q_in       = '0;
        c_in.len   = lenE_r;
        c_in.act   = actE_r;
        c_in.st    = stE_r;
        c_in.sx    = cE_r.sx;
        c_in.fd    = cE_r.fd;
        c_in.fds   = cE_r.fds;
        c_in.tp    = TPW'(stiff_r) * TPW'(eE_r);
      end
      assign v_in = vE_r;
    end else begin : g_next
      assign rem_in = dv_rem_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign bit_in = '0;
      assign c_in   = dv_c_r[j-1];
      assign v_in   = dv_v_r[j-1];
    end
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r2[l] = {rem_in[l], bit_in[l]};
        ge[l] = r2[l] >= {1'b0, c_in.len};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          dv_rem_r[j][l] <= ge[l] ? MW'(r2[l] - {1'b0, c_in.len}) : MW'(r2[l]);
          dv_q_r[j][l]   <= {q_in[l][QW-2:0], ge[l]};
        end
        dv_c_r[j] <= c_in;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j] <= v_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stages
  // ---------------------------------------------------------------------------
  dvc_t dc;
  logic [2:0][QW-1:0] n_c;
  logic [QW-1:0] c_c;
  logic [TW-1:0] t_c;
  assign dc = dv_c_r[QW-1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = dc.act ? dv_q_r[QW-1][i] : '0;
    end
    c_c = dc.act ? dv_q_r[QW-1][3] : '0;
    t_c = TW'(dc.tp >> FRAC_BITS);
  end

  // M1: n_i n_j and split tension products
  logic [PAIRS-1:0][PMW-1:0] pm1_r;
  logic [PAIRS-1:0] ps1_r;
  logic [2:0][TH+QW-1:0] fh1_r;
  logic [2:0][TL+QW-1:0] fl1_r;
  logic [QW-1:0] c1_r;
  dvc_t m1c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PAIRS; k++) begin
        pm1_r[k] <= PMW'(n_c[PI[k]]) * PMW'(n_c[PJ[k]]);
        ps1_r[k] <= dc.sx[PI[k]] ^ dc.sx[PJ[k]];
      end
      for (int i = 0; i < 3; i++) begin
        fh1_r[i] <= (TH+QW)'(t_c[TW-1:TL]) * (TH+QW)'(n_c[i]);
        fl1_r[i] <= (TL+QW)'(t_c[TL-1:0]) * (TL+QW)'(n_c[i]);
      end
      c1_r  <= c_c;
      m1c_r <= dc;
    end
  end

  // M2: p, delta - p, and the full force sum
  logic [PAIRS-1:0][PW-1:0]  p_c;
  logic [PAIRS-1:0][SPW-1:0] psg_c, d_c;
  logic [2:0][FCW-1:0]       fcomb_c;
  logic [2:0][63:0]          ft_c, fd_c, f_c;
  always_comb begin
    for (int k = 0; k < PAIRS; k++) begin
      p_c[k]   = PW'(pm1_r[k] >> UB);
      psg_c[k] = ps1_r[k] ? (~SPW'(p_c[k]) + 1'b1) : SPW'(p_c[k]);
      d_c[k]   = ((PI[k] == PJ[k]) ? UNIT_ONE : '0) - psg_c[k];
    end
    for (int i = 0; i < 3; i++) begin
      fcomb_c[i] = (FCW'(fh1_r[i]) << TL) + FCW'(fl1_r[i]);
      ft_c[i]    = 64'(fcomb_c[i] >> UB);
      fd_c[i]    = 64'(m1c_r.fd[i]);
      // f = -sgn(n) * ft - sgn(dv) * fd
      f_c[i]     = (m1c_r.sx[i] ? ft_c[i] : (~ft_c[i] + 1'b1))
                 + (m1c_r.fds[i] ? fd_c[i] : (~fd_c[i] + 1'b1));
    end
  end

  logic [PAIRS-1:0][SPW-1:0] p2_r;
  logic [PAIRS-1:0][DMW-1:0] dm2_r;
  logic [PAIRS-1:0] ds2_r;
  logic [QW-1:0] c2_r;
  tail_t t2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PAIRS; k++) begin
        p2_r[k]  <= psg_c[k];
        dm2_r[k] <= d_c[k][SPW-1] ? DMW'(~d_c[k] + 1'b1) : DMW'(d_c[k]);
        ds2_r[k] <= d_c[k][SPW-1];
      end
      c2_r     <= c1_r;
      t2_r.f   <= f_c;
      t2_r.act <= m1c_r.act;
      t2_r.st  <= m1c_r.st;
    end
  end

  // M3: c * (delta - p)
  logic [PAIRS-1:0][CDW-1:0] cd3_r;
  logic [PAIRS-1:0][SPW-1:0] p3_r;
  logic [PAIRS-1:0] ds3_r;
  tail_t t3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PAIRS; k++) begin
        cd3_r[k] <= CDW'(c2_r) * CDW'(dm2_r[k]);
      end
      p3_r  <= p2_r;
      ds3_r <= ds2_r;
      t3_r  <= t2_r;
    end
  end

  // M4: m = p + c (delta - p)
  logic [PAIRS-1:0][CSW-1:0] cds_c;
  logic [PAIRS-1:0][MSW-1:0] pext_c, m_c;
  always_comb begin
    for (int k = 0; k < PAIRS; k++) begin
      cds_c[k]  = CSW'(cd3_r[k] >> UB);
      pext_c[k] = {{(MSW-SPW){p3_r[k][SPW-1]}}, p3_r[k]};
      m_c[k]    = ds3_r[k] ? (pext_c[k] - MSW'(cds_c[k])) : (pext_c[k] + MSW'(cds_c[k]));
    end
  end

  logic [PAIRS-1:0][MMW-1:0] mm4_r;
  logic [PAIRS-1:0] ms4_r;
  tail_t t4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PAIRS; k++) begin
        mm4_r[k] <= m_c[k][MSW-1] ? MMW'(~m_c[k] + 1'b1) : MMW'(m_c[k]);
        ms4_r[k] <= m_c[k][MSW-1];
      end
      t4_r <= t3_r;
    end
  end

  // M5: stiffness * m
  logic [PAIRS-1:0][SMW-1:0] sm5_r;
  logic [PAIRS-1:0] ms5_r;
  tail_t t5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < PAIRS; k++) begin
        sm5_r[k] <= SMW'(stiff_r) * SMW'(mm4_r[k]);
      end
      ms5_r <= ms4_r;
      t5_r  <= t4_r;
    end
  end

  // Output: jac = -(stiffness * m), zero when not under tension; clip all nine.
  logic [PAIRS-1:0][63:0] sj_c, jac_c;
  logic [8:0][DW:0] sat_c;
  csfj_pkg::res_t res_c;
  always_comb begin
    for (int k = 0; k < PAIRS; k++) begin
      sj_c[k]  = 64'(sm5_r[k] >> UB);
      jac_c[k] = !t5_r.act ? 64'd0 : (ms5_r[k] ? sj_c[k] : (~sj_c[k] + 1'b1));
    end
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = sat_w(t5_r.f[i]);
    end
    for (int k = 0; k < PAIRS; k++) begin
      sat_c[3+k] = sat_w(jac_c[k]);
    end
    res_c.force_x   = sat_c[0][DW-1:0];
    res_c.force_y   = sat_c[1][DW-1:0];
    res_c.force_z   = sat_c[2][DW-1:0];
    res_c.jac_xx    = sat_c[3][DW-1:0];
    res_c.jac_xy    = sat_c[4][DW-1:0];
    res_c.jac_xz    = sat_c[5][DW-1:0];
    res_c.jac_yy    = sat_c[6][DW-1:0];
    res_c.jac_yz    = sat_c[7][DW-1:0];
    res_c.jac_zz    = sat_c[8][DW-1:0];
    res_c.stretched = t5_r.st;
    res_c.saturated = sat_c[0][DW] | sat_c[1][DW] | sat_c[2][DW] | sat_c[3][DW]
                    | sat_c[4][DW] | sat_c[5][DW] | sat_c[6][DW] | sat_c[7][DW]
                    | sat_c[8][DW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_c;
    end
  end

  // Valid chain outside the generated sections
  logic [4:0] vm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vE_r        <= 1'b0;
      vm_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= acc && is_spring;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vE_r        <= sq_v_r[RT-1];
      vm_r        <= {vm_r[3:0], dv_v_r[QW-1]};
      out_valid_r <= vm_r[4];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !is_spring) |=> !v0_r)
    else $error("load request entered the result pipeline");

  a_spring_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_spring) |=> v0_r)
    else $error("spring request lost at pipeline entry");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[QW-1] && dv_c_r[QW-1].act) |-> (dv_q_r[QW-1][3] <= QW'(64'd1 << UB)))
    else $error("length ratio above one");

  a_slack_jac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.stretched) |->
      (out_data_r.jac_xx == '0 && out_data_r.jac_xy == '0 && out_data_r.jac_xz == '0 &&
       out_data_r.jac_yy == '0 && out_data_r.jac_yz == '0 && out_data_r.jac_zz == '0))
    else $error("nonzero Jacobian on a slack spring");

endmodule
`default_nettype wire

@@ tb/csfj_checker.sv @@
`timescale 1ns / 1ps
// Watches the request, result and config ports of the spring unit, keeps its own copy
// of the particle store and the two coefficients, and compares every result.
module csfj_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  csfj_in_if                              in_ch,
  csfj_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [csfj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csfj_pkg::DATA_W-1:0]     cfg_data,
  output int                              errors,
  output int                              pending
);

  localparam longint CAP62 = longint'(1) << 62;

  logic signed [csfj_pkg::DATA_W-1:0] pos_mem [0:1023][0:2];
  logic signed [csfj_pkg::DATA_W-1:0] vel_mem [0:1023][0:2];
  logic [csfj_pkg::DATA_W-1:0]        stiff_q;
  logic [csfj_pkg::DATA_W-1:0]        damp_q;
  csfj_pkg::res_t                     expected_forces [$];
  int                                 err_cnt;
  int                                 pend_cnt;

  assign errors  = err_cnt;
  assign pending = pend_cnt;

  function automatic logic [63:0] umag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // |a*b| >> s, capped at 2^62, sign restored (truncation toward zero)
  function automatic longint scaled_prod(longint a, longint b, int s);
    logic [127:0] p;
    longint       r;
    p = {64'b0, umag(a)} * {64'b0, umag(b)};
    p = p >> s;
    r = (p > 128'(CAP62)) ? CAP62 : longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] rem, res, bitv;
    rem = x;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [csfj_pkg::DATA_W-1:0] clip32(longint v, inout logic clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic csfj_pkg::res_t spring_result(csfj_pkg::req_t r);
    longint         dx [3], dv [3], n [3], f [3], jac [3][3];
    logic [65:0]    sq_sum;
    logic [63:0]    len, e, c, t;
    logic [127:0]   tprod;
    logic           str, live, clipped;
    longint         p, d, m;
    csfj_pkg::res_t o;
    sq_sum = 0;
    for (int i = 0; i < 3; i++) begin
      dx[i] = longint'(pos_mem[r.index_a][i]) - longint'(pos_mem[r.index_b][i]);
      dv[i] = longint'(vel_mem[r.index_a][i]) - longint'(vel_mem[r.index_b][i]);
      sq_sum = sq_sum + 66'(umag(dx[i]) * umag(dx[i]));
      n[i] = 0;
    end
    if (sq_sum[65:64] == 0) len = int_sqrt(sq_sum[63:0]);
    else                    len = 2 * int_sqrt(sq_sum[65:2]);
    str  = len >= 64'(r.rest_length);
    live = str && len != 0;
    c = 0;
    t = 0;
    if (live) begin
      e = len - 64'(r.rest_length);
      for (int i = 0; i < 3; i++) begin
        n[i] = longint'((umag(dx[i]) << csfj_pkg::UNIT_BITS) / len);
        if (dx[i] < 0) n[i] = -n[i];
      end
      c = (e << csfj_pkg::UNIT_BITS) / len;
      // stiffness * e can pass 2^64; keep it exact
      tprod = (128'(stiff_q) * 128'(e)) >> csfj_pkg::FRAC_BITS_DEF;
      t = tprod[63:0];
    end
    for (int i = 0; i < 3; i++) begin
      f[i] = -scaled_prod(longint'(t), n[i], csfj_pkg::UNIT_BITS)
             - scaled_prod(longint'(damp_q), dv[i], csfj_pkg::FRAC_BITS_DEF);
      for (int j = 0; j < 3; j++) begin
        jac[i][j] = 0;
        if (live) begin
          p = scaled_prod(n[i], n[j], csfj_pkg::UNIT_BITS);
          d = ((i == j) ? (longint'(1) << csfj_pkg::UNIT_BITS) : 0) - p;
          m = p + scaled_prod(longint'(c), d, csfj_pkg::UNIT_BITS);
          jac[i][j] = -scaled_prod(longint'(stiff_q), m, csfj_pkg::UNIT_BITS);
        end
      end
    end
    clipped = 1'b0;
    o.force_x   = clip32(f[0], clipped);
    o.force_y   = clip32(f[1], clipped);
    o.force_z   = clip32(f[2], clipped);
    o.jac_xx    = clip32(jac[0][0], clipped);
    o.jac_xy    = clip32(jac[0][1], clipped);
    o.jac_xz    = clip32(jac[0][2], clipped);
    o.jac_yy    = clip32(jac[1][1], clipped);
    o.jac_yz    = clip32(jac[1][2], clipped);
    o.jac_zz    = clip32(jac[2][2], clipped);
    o.stretched = str;
    o.saturated = clipped;
    return o;
  endfunction

  always @(posedge clk) begin
    csfj_pkg::res_t want;
    if (!rst_n) begin
      expected_forces.delete();
      stiff_q  <= '0;
      damp_q   <= '0;
      err_cnt  <= 0;
      pend_cnt <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == csfj_pkg::REG_STIFFNESS) stiff_q <= cfg_data;
        else if (cfg_index == csfj_pkg::REG_DAMPING) damp_q <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_forces.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10) $display("result with nothing expected: %p", out_ch.data);
        end else begin
          want = expected_forces.pop_front();
          if (out_ch.data !== want) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < 10) begin
              $display("mismatch f=(%h %h %h) exp (%h %h %h)", out_ch.data.force_x,
                       out_ch.data.force_y, out_ch.data.force_z, want.force_x,
                       want.force_y, want.force_z);
              $display("  jac=(%h %h %h %h %h %h) exp (%h %h %h %h %h %h)",
                       out_ch.data.jac_xx, out_ch.data.jac_xy, out_ch.data.jac_xz,
                       out_ch.data.jac_yy, out_ch.data.jac_yz, out_ch.data.jac_zz,
                       want.jac_xx, want.jac_xy, want.jac_xz,
                       want.jac_yy, want.jac_yz, want.jac_zz);
              $display("  stretched=%b saturated=%b exp %b %b", out_ch.data.stretched,
                       out_ch.data.saturated, want.stretched, want.saturated);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.req_type == csfj_pkg::REQ_SPRING) begin
          expected_forces.push_back(spring_result(in_ch.data));
        end else begin
          pos_mem[in_ch.data.index_a][0] = in_ch.data.pos_x;
          pos_mem[in_ch.data.index_a][1] = in_ch.data.pos_y;
          pos_mem[in_ch.data.index_a][2] = in_ch.data.pos_z;
          vel_mem[in_ch.data.index_a][0] = in_ch.data.vel_x;
          vel_mem[in_ch.data.index_a][1] = in_ch.data.vel_y;
          vel_mem[in_ch.data.index_a][2] = in_ch.data.vel_z;
        end
      end
      pend_cnt <= expected_forces.size();
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the spring force / Jacobian unit. The checker beside the
// DUT does all prediction; this module only drives requests, config and back-pressure.
module testbench;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [csfj_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [csfj_pkg::DATA_W-1:0]    cfg_data;
  int                             errors;
  int                             pending;
  bit                             quiet;        // no idling on either side
  bit                             loaded [0:1023];
  int                             loaded_list [$];

  csfj_in_if  in_ch ();
  csfj_out_if out_ch ();

  cloth_spring_force_jacobian DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  csfj_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Hard stop; the slowest legal run is far below this.
  initial begin
    #6000000;
    $display("** cloth_spring_force_jacobian: FAILED **");
    $finish;
  end

  // Coordinates: mostly small so springs land near their rest length, plus extremes.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h80000000;
      1:       return 32'h7fffffff;
      2:       return $urandom;
      3:       return 32'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
      default: return 32'(int'($urandom_range(0, 32'h800000)) - 32'h400000);
    endcase
  endfunction

  function automatic logic [31:0] rand_rest();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h600000);
    endcase
  endfunction

  function automatic csfj_pkg::req_t load_req(int idx, logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz, logic [31:0] vx,
                                              logic [31:0] vy, logic [31:0] vz);
    csfj_pkg::req_t r;
    r.req_type    = csfj_pkg::REQ_LOAD;
    r.index_a     = idx[csfj_pkg::IDX_W-1:0];
    r.index_b     = $urandom;     // don't-care bits still get exercised
    r.rest_length = $urandom;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    r.vel_x = vx; r.vel_y = vy; r.vel_z = vz;
    return r;
  endfunction

  function automatic csfj_pkg::req_t spring_req(int a, int b, logic [31:0] rest);
    csfj_pkg::req_t r;
    r.req_type    = csfj_pkg::REQ_SPRING;
    r.index_a     = a[csfj_pkg::IDX_W-1:0];
    r.index_b     = b[csfj_pkg::IDX_W-1:0];
    r.rest_length = rest;
    r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
    r.vel_x = $urandom; r.vel_y = $urandom; r.vel_z = $urandom;
    return r;
  endfunction

  // One request: offered at a falling edge, held until taken at a rising edge. Valid
  // stays high between back-to-back requests; an idle burst or set_coeffs lowers it.
  task automatic push_request(csfj_pkg::req_t r);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.req_type == csfj_pkg::REQ_LOAD && !loaded[r.index_a]) begin
      loaded[r.index_a] = 1'b1;
      loaded_list.push_back(r.index_a);
    end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic pick_spring();
    int a, b;
    a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    b = ($urandom_range(0, 15) == 0) ? a
        : loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    push_request(spring_req(a, b, rand_rest()));
  endtask

  // Config only while idle: drain results, then a margin before touching the
  // coefficients.
  task automatic set_coeffs(logic [31:0] k, logic [31:0] damp);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (90) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= csfj_pkg::REG_STIFFNESS;
    cfg_data  <= k;
    @(negedge clk);
    cfg_index <= csfj_pkg::REG_DAMPING;
    cfg_data  <= damp;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stall bursts, one long hold-off while springs stream in
  // so the pipeline fills and back-pressures the request side.
  initial begin
    int n;
    int cycles;
    bit held;
    out_ch.ready = 1'b0;
    cycles = 0;
    held = 1'b0;
    @(posedge rst_n);
    while (1) begin
      @(negedge clk);
      cycles++;
      if (!held && cycles >= 1500) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        cycles += 400;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
        cycles += n - 1;
      end else begin
        n = $urandom_range(1, 20);
        out_ch.ready <= 1'b1;
        repeat (n - 1) @(negedge clk);
        cycles += n - 1;
      end
    end
  end

  initial begin
    logic [31:0] ks [5];
    logic [31:0] ds [5];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = csfj_pkg::REG_STIFFNESS;
    cfg_data    = '0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unit stiffness, half damping.
    set_coeffs(32'h00010000, 32'h00008000);
    push_request(load_req(0, 0, 0, 0, 0, 0, 0));
    push_request(load_req(1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h80000000, 32'h7fffffff));
    push_request(load_req(1, 32'h00010000, 0, 0, 32'h00020000, 0, 32'hffff0000));
    push_request(load_req(2, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h7fffffff, 32'h80000000));
    push_request(load_req(3, 32'h00030000, 32'h00040000, 0, 0, 32'h00010000, 0));
    push_request(spring_req(1, 0, 32'h0));            // stretched, unit direction
    push_request(spring_req(1, 0, 32'h00020000));     // compressed
    push_request(spring_req(0, 0, 32'h0));            // same index, zero rest
    push_request(spring_req(3, 3, 32'h00050000));     // zero length, nonzero rest
    push_request(spring_req(1023, 2, 32'h0));         // squared length past 2^64
    push_request(spring_req(1023, 2, 32'hffffffff));
    push_request(spring_req(2, 1023, 32'h00010000));
    push_request(spring_req(3, 0, 32'h00050000));     // exactly at rest length
    push_request(spring_req(3, 0, 32'h00010000));
    push_request(spring_req(0, 1023, 32'hffffffff));

    // Random phases over several coefficient settings, extremes included.
    ks[0] = 32'h0;        ds[0] = 32'h0;
    ks[1] = 32'hffffffff; ds[1] = 32'hffffffff;
    ks[2] = $urandom;     ds[2] = $urandom_range(0, 32'h40000);
    ks[3] = $urandom_range(0, 32'h200000); ds[3] = $urandom;
    ks[4] = 32'h00040000; ds[4] = 32'h00001000;
    for (int ph = 0; ph < 5; ph++) begin
      set_coeffs(ks[ph], ds[ph]);
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 350; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          push_request(load_req(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                : $urandom_range(0, 31),
                                rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord()));
        end else begin
          pick_spring();
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** cloth_spring_force_jacobian: PASSED **");
    end else begin
      $display("** cloth_spring_force_jacobian: FAILED **");
    end
    $finish;
  end
endmodule
